// ----- src/rlcc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlcc_pkg
// Shared types and constants for the red line crossing counter: register
// indexes, reset values, field widths and the structs passed between units.
// ----------------------------------------------------------------------------
package rlcc_pkg;

    // field widths
    localparam int unsigned ColorW  = 8;
    localparam int unsigned RowW    = 10;
    localparam int unsigned ColW    = 11;
    localparam int unsigned HeightW = 11;
    localparam int unsigned WidthW  = 12;
    localparam int unsigned CountW  = 21;
    localparam int unsigned TotalW  = 16;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 21;

    // stream payload widths (whole bytes)
    localparam int unsigned InDataW  = 48;
    localparam int unsigned OutDataW = 32;

    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
    localparam logic [ColorW-1:0] MaskOn   = {ColorW{1'b1}};
    localparam logic [ColorW-1:0] MaskOff  = '0;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_BLUE_MAX        = 3'd0,
        REG_GREEN_MAX       = 3'd1,
        REG_RED_MIN         = 3'd2,
        REG_ROI_TOP         = 3'd3,
        REG_ROI_HEIGHT      = 3'd4,
        REG_ROI_LEFT        = 3'd5,
        REG_ROI_WIDTH       = 3'd6,
        REG_COUNT_THRESHOLD = 3'd7
    } cfg_idx_t;

    // reset values
    localparam logic [ColorW-1:0]  BlueMaxRst   = 8'd50;
    localparam logic [ColorW-1:0]  GreenMaxRst  = 8'd50;
    localparam logic [ColorW-1:0]  RedMinRst    = 8'd200;
    localparam logic [RowW-1:0]    RoiTopRst    = 10'd270;
    localparam logic [HeightW-1:0] RoiHeightRst = 11'd50;
    localparam logic [ColW-1:0]    RoiLeftRst   = 11'd0;
    localparam logic [WidthW-1:0]  RoiWidthRst  = 12'd640;
    localparam logic [CountW-1:0]  ThresholdRst = 21'd1000;

    // configuration register file contents
    typedef struct packed {
        logic [ColorW-1:0]  blue_max;
        logic [ColorW-1:0]  green_max;
        logic [ColorW-1:0]  red_min;
        logic [RowW-1:0]    roi_top;
        logic [HeightW-1:0] roi_height;
        logic [ColW-1:0]    roi_left;
        logic [WidthW-1:0]  roi_width;
        logic [CountW-1:0]  count_threshold;
    } cfg_t;

    // one pixel as held in the input stage
    typedef struct packed {
        logic [ColorW-1:0] blue;
        logic [ColorW-1:0] green;
        logic [ColorW-1:0] red;
        logic [RowW-1:0]   pixel_row;
        logic [ColW-1:0]   pixel_col;
        logic              frame_end;
    } pixel_t;

    // classifier result for one pixel
    typedef struct packed {
        logic is_red;
        logic in_region;
    } class_t;

    // line tracker status after one pixel
    typedef struct packed {
        logic              line_high;
        logic              crossed;
        logic [TotalW-1:0] crossings;
    } track_t;

endpackage : rlcc_pkg
`default_nettype wire

// ----- src/rlcc_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlcc_cfg_regs
// Configuration register file: decodes the write port and holds the color
// limits, the counting region and the count threshold.
// ----------------------------------------------------------------------------
module rlcc_cfg_regs
    import rlcc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_addr,
    input  wire logic [CfgDataW-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // write decode, values truncated to each register width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                REG_BLUE_MAX:        cfg_next.blue_max        = cfg_data[ColorW-1:0];
                REG_GREEN_MAX:       cfg_next.green_max       = cfg_data[ColorW-1:0];
                REG_RED_MIN:         cfg_next.red_min         = cfg_data[ColorW-1:0];
                REG_ROI_TOP:         cfg_next.roi_top         = cfg_data[RowW-1:0];
                REG_ROI_HEIGHT:      cfg_next.roi_height      = cfg_data[HeightW-1:0];
                REG_ROI_LEFT:        cfg_next.roi_left        = cfg_data[ColW-1:0];
                REG_ROI_WIDTH:       cfg_next.roi_width       = cfg_data[WidthW-1:0];
                REG_COUNT_THRESHOLD: cfg_next.count_threshold = cfg_data[CountW-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blue_max        <= BlueMaxRst;
            cfg_reg.green_max       <= GreenMaxRst;
            cfg_reg.red_min         <= RedMinRst;
            cfg_reg.roi_top         <= RoiTopRst;
            cfg_reg.roi_height      <= RoiHeightRst;
            cfg_reg.roi_left        <= RoiLeftRst;
            cfg_reg.roi_width       <= RoiWidthRst;
            cfg_reg.count_threshold <= ThresholdRst;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule : rlcc_cfg_regs
`default_nettype wire

// ----- src/rlcc_classify.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlcc_classify
// Per-pixel color test and region membership test, purely combinational.
// ----------------------------------------------------------------------------
module rlcc_classify
    import rlcc_pkg::*;
(
    input  wire pixel_t pix,
    input  wire cfg_t   cfg,
    output class_t      cls
);

    logic [RowW-1:0] row_off;
    logic [ColW-1:0] col_off;
    logic            row_in;
    logic            col_in;

    // color limits, all strict
    assign cls.is_red = (pix.blue < cfg.blue_max) && (pix.green < cfg.green_max)
                        && (pix.red > cfg.red_min);

    // offset from region start, valid only when at or past the start
    assign row_off = pix.pixel_row - cfg.roi_top;
    assign col_off = pix.pixel_col - cfg.roi_left;

    assign row_in = (pix.pixel_row >= cfg.roi_top)
                    && ({{(HeightW-RowW){1'b0}}, row_off} < cfg.roi_height);
    assign col_in = (pix.pixel_col >= cfg.roi_left)
                    && ({{(WidthW-ColW){1'b0}}, col_off} < cfg.roi_width);

    assign cls.in_region = row_in && col_in;

endmodule : rlcc_classify
`default_nettype wire

// ----- src/rlcc_tracker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlcc_tracker
// Frame red-pixel counter with line presence hysteresis and crossing total.
// Updates once per pixel that moves to the output register.
// ----------------------------------------------------------------------------
module rlcc_tracker
    import rlcc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire class_t            cls,
    input  wire logic              frame_end,
    input  wire logic [CountW-1:0] count_threshold,
    output track_t                 status
);

    logic [CountW-1:0] red_count_reg;
    logic [CountW-1:0] red_count_next;
    logic              line_state_reg;
    logic              line_state_next;
    logic [TotalW-1:0] total_reg;
    logic [TotalW-1:0] total_next;
    logic [CountW-1:0] count_after;
    logic              crossed;

    // saturating count including the current pixel
    assign count_after = red_count_reg
                         + CountW'(cls.is_red && cls.in_region && (red_count_reg != CountMax));

    // frame end check
    always_comb
    begin
        red_count_next  = count_after;
        line_state_next = line_state_reg;
        total_next      = total_reg;
        crossed         = 1'b0;
        if (frame_end)
        begin
            red_count_next = '0;
            if (!line_state_reg && (count_after > count_threshold))
            begin
                line_state_next = 1'b1;
            end
            else if (line_state_reg && (count_after < count_threshold))
            begin
                line_state_next = 1'b0;
                total_next      = total_reg + TotalW'(1);
                crossed         = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_count_reg  <= '0;
            line_state_reg <= 1'b0;
            total_reg      <= '0;
        end
        else if (advance)
        begin
            red_count_reg  <= red_count_next;
            line_state_reg <= line_state_next;
            total_reg      <= total_next;
        end
    end

    assign status.line_high = line_state_next;
    assign status.crossed   = crossed;
    assign status.crossings = total_next;

endmodule : rlcc_tracker
`default_nettype wire

// ----- src/red_line_crossing_counter_core.sv -----
// A transfer goes to the input register and its result to the output register.
// Throughput: one pixel per cycle unless stalled; the input register feeds the
// classifier and frame counter, whose result lands in the output register in one pass.
// Either register may hold while the output is stalled; ready follows the output.
// Reset clears valid flags, counter, line state and crossing total, and loads
// the configuration registers with their default limits and region.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// red_line_crossing_counter_core
// Top level: pixel stream in, mask and line crossing status stream out, with a
// configuration write port for color limits, region and count threshold.
// ----------------------------------------------------------------------------
module red_line_crossing_counter_core
    import rlcc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // pixel input
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // [7:0] blue, [15:8] green, [23:16] red, [33:24] pixel_row, [44:34] pixel_col
    input  wire logic [InDataW-1:0]  s_axis_tdata,
    input  wire logic                s_axis_tlast,   // frame_end
    // result output
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // [7:0] mask_pixel, [8] in_region, [9] line_high, [10] crossed, [26:11] crossings
    output logic [OutDataW-1:0]      m_axis_tdata,
    // configuration write
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_addr,
    input  wire logic [CfgDataW-1:0] cfg_data
);

    cfg_t   cfg;
    class_t cls;
    track_t status;

    pixel_t pix_reg;
    logic   pix_valid_reg;
    logic   out_valid_reg;
    logic [ColorW-1:0] out_mask_reg;
    logic   out_region_reg;
    track_t out_status_reg;

    logic   out_free;
    logic   advance;
    logic   in_xfer;

    // handshake
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = pix_valid_reg && out_free;
    assign s_axis_tready = !pix_valid_reg || out_free;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    rlcc_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            pix_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pix_reg.blue      <= s_axis_tdata[7:0];
            pix_reg.green     <= s_axis_tdata[15:8];
            pix_reg.red       <= s_axis_tdata[23:16];
            pix_reg.pixel_row <= s_axis_tdata[33:24];
            pix_reg.pixel_col <= s_axis_tdata[44:34];
            pix_reg.frame_end <= s_axis_tlast;
        end
    end

    rlcc_classify u_classify (
        .pix (pix_reg),
        .cfg (cfg),
        .cls (cls)
    );

    rlcc_tracker u_tracker (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .cls             (cls),
        .frame_end       (pix_reg.frame_end),
        .count_threshold (cfg.count_threshold),
        .status          (status)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= pix_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_mask_reg   <= cls.is_red ? MaskOn : MaskOff;
            out_region_reg <= cls.in_region;
            out_status_reg <= status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OutDataW-ColorW-3-TotalW){1'b0}},
                            out_status_reg.crossings,
                            out_status_reg.crossed,
                            out_status_reg.line_high,
                            out_region_reg,
                            out_mask_reg};

endmodule : red_line_crossing_counter_core
`default_nettype wire

// ----- src/rlcc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlcc_checker
// Port-level checks on the result stream of the red line crossing counter,
// bound to the top level.
// ----------------------------------------------------------------------------
module rlcc_checker
    import rlcc_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [OutDataW-1:0] m_axis_tdata
);

    logic [TotalW-1:0] last_total_reg;
    logic [ColorW-1:0] mask;
    logic              line_high;
    logic              crossed;
    logic [TotalW-1:0] crossings;

    assign mask      = m_axis_tdata[7:0];
    assign line_high = m_axis_tdata[9];
    assign crossed   = m_axis_tdata[10];
    assign crossings = m_axis_tdata[26:11];

    // crossing total of the last transferred result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_total_reg <= '0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            last_total_reg <= crossings;
        end
    end

    // mask is all ones or all zeros
    a_mask_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (mask == MaskOn || mask == MaskOff))
        else $error("mask pixel is neither on nor off");

    // a crossing leaves the line low
    a_cross_low: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && crossed) |-> !line_high)
        else $error("crossed raised while line still high");

    // total steps by one exactly on a crossing
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (crossings == (last_total_reg + TotalW'(crossed))))
        else $error("crossing total out of step with crossed");

    // stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

endmodule : rlcc_checker

bind red_line_crossing_counter_core rlcc_checker u_rlcc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
